// ===== rtl/core/rg565_pkg.sv =====
// ----------------------------------------------------------------------------
// rg565_pkg: shared types and constants
// Channel widths, luminance weights and stage control bundle for the
// RGBA to gray RGB565 converter.
// ----------------------------------------------------------------------------
package rg565_pkg;

   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned NUM_CHAN = 3;

   // channel lanes
   localparam int unsigned CH_RED   = 0;
   localparam int unsigned CH_GREEN = 1;
   localparam int unsigned CH_BLUE  = 2;

   // luminance weights, sum is 256
   localparam logic [CHAN_W-1:0] LUM_RED   = 8'd77;
   localparam logic [CHAN_W-1:0] LUM_GREEN = 8'd150;
   localparam logic [CHAN_W-1:0] LUM_BLUE  = 8'd29;

   // silhouette threshold: alpha strictly above counts as opaque
   localparam logic [CHAN_W-1:0] SIL_THRESH = 8'd128;
   localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [15:0]       blend_type;
   typedef logic [15:0]       prod_type;

   // per-pixel control that travels beside the data
   typedef struct packed {
      logic sil;
      logic black;
      logic last;
   } ctl_type;

endpackage

// ===== rtl/core/rg565_if.sv =====
// ----------------------------------------------------------------------------
// rg565 channel interfaces
// Valid/ready channels for input pixels, gray results and the mode write.
// ----------------------------------------------------------------------------
interface rg565_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic       last_pixel;

   modport source (output valid, red, green, blue, alpha, last_pixel, input ready);
   modport sink   (input valid, red, green, blue, alpha, last_pixel, output ready);
endinterface

interface rg565_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_565;
   logic [7:0]  gray_level;
   logic        last_out;

   modport source (output valid, pixel_565, gray_level, last_out, input ready);
   modport sink   (input valid, pixel_565, gray_level, last_out, output ready);
endinterface

interface rg565_csr_if;
   logic valid;
   logic ready;
   logic silhouette_mode;

   modport source (output valid, silhouette_mode, input ready);
   modport sink   (input valid, silhouette_mode, output ready);
endinterface

// ===== rtl/core/rgba_to_gray_rgb565.sv =====
// ----------------------------------------------------------------------------
// rgba_to_gray_rgb565: RGBA8888 pixel to gray RGB565
// Blends each pixel over white, takes luminance and packs it as RGB565,
// or renders a black/white silhouette from alpha.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus  : one RGBA8888 pixel per transfer plus a last-pixel mark.
//   rsp_bus  : one result per pixel, in order: RGB565 word, 8-bit gray and
//              the copied last mark.
//   csr_bus  : writes the silhouette mode bit; always ready. Write it only
//              while no pixel is in flight. Each pixel uses the mode that
//              holds when it enters.
//   Pipeline : five register stages: blend product, reciprocal estimate,
//              quotient fix, weight products, sum and pack.
//   Throughput: one pixel per cycle while rsp_bus is ready; every stage advances independently.
//   Reset    : synchronous; empties the pipeline and clears the mode to 0.
//   Stall    : when rsp_bus is not ready the last stage holds its result
//              and bubbles close up behind it; req_bus drops ready only
//              once all five stages are full.
// ----------------------------------------------------------------------------
module rgba_to_gray_rgb565
   import rg565_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rg565_req_if.sink   req_bus,
   rg565_rsp_if.source rsp_bus,
   rg565_csr_if.sink   csr_bus
);

   // mode register
   logic mode_ff;

   // stage valid bits and per-stage ready
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // stage payloads
   blend_type x1_ff  [NUM_CHAN];
   ctl_type   c1_ff;
   blend_type x2_ff  [NUM_CHAN];
   chan_type  q2_ff  [NUM_CHAN];
   ctl_type   c2_ff;
   chan_type  q3_ff  [NUM_CHAN];
   ctl_type   c3_ff;
   prod_type  p4_ff  [NUM_CHAN];
   ctl_type   c4_ff;
   logic [15:0] pix5_ff;
   chan_type    gray5_ff;
   logic        last5_ff;

   // next values
   blend_type x1_in  [NUM_CHAN];
   ctl_type   c1_in;
   chan_type  q2_in  [NUM_CHAN];
   chan_type  q3_in  [NUM_CHAN];
   logic [16:0] r3_full [NUM_CHAN];
   prod_type  p4_in  [NUM_CHAN];
   chan_type  gray5_in;
   logic [17:0] lum_sum;
   chan_type  chan_in [NUM_CHAN];

   // ready ripples back from the output
   assign rdy5 = !v5_ff || rsp_bus.ready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_bus.ready = rdy1;
   assign csr_bus.ready = 1'b1;

   assign chan_in[CH_RED]   = req_bus.red;
   assign chan_in[CH_GREEN] = req_bus.green;
   assign chan_in[CH_BLUE]  = req_bus.blue;

   // stage 1: blend numerator c*a + 255*(255-a)
   always_comb begin
      logic [CHAN_W-1:0] na;
      logic [16:0]       num;
      na = CHAN_MAX - req_bus.alpha;
      for (int i = 0; i < NUM_CHAN; i++) begin
         num = 17'(chan_in[i]) * 17'(req_bus.alpha) + {1'b0, na, 8'h00} - 17'(na);
         x1_in[i] = num[15:0];
      end
      c1_in.sil   = mode_ff;
      c1_in.black = (req_bus.alpha > SIL_THRESH);
      c1_in.last  = req_bus.last_pixel;
   end

   // stage 2: quotient estimate x*257 >> 16, never above x/255
   always_comb begin
      logic [23:0] est;
      for (int i = 0; i < NUM_CHAN; i++) begin
         est = {x1_ff[i], 8'h00} + 24'(x1_ff[i]);
         q2_in[i] = est[23:16];
      end
   end

   // stage 3: remainder check, bump the quotient by one when needed
   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         r3_full[i] = 17'(x2_ff[i]) + 17'(q2_ff[i]) - {1'b0, q2_ff[i], 8'h00};
         q3_in[i]   = (r3_full[i] >= 17'(CHAN_MAX)) ? q2_ff[i] + 8'd1 : q2_ff[i];
      end
   end

   // stage 4: luminance weight products
   always_comb begin
      p4_in[CH_RED]   = 16'(q3_ff[CH_RED])   * 16'(LUM_RED);
      p4_in[CH_GREEN] = 16'(q3_ff[CH_GREEN]) * 16'(LUM_GREEN);
      p4_in[CH_BLUE]  = 16'(q3_ff[CH_BLUE])  * 16'(LUM_BLUE);
   end

   // stage 5: sum, scale and select silhouette
   always_comb begin
      lum_sum = 18'(p4_ff[CH_RED]) + 18'(p4_ff[CH_GREEN]) + 18'(p4_ff[CH_BLUE]);
      if (c4_ff.sil) begin
         gray5_in = c4_ff.black ? '0 : CHAN_MAX;
      end else begin
         gray5_in = lum_sum[15:8];
      end
   end

   // control: valid bits and mode
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         v5_ff   <= 1'b0;
         mode_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_bus.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (csr_bus.valid && csr_bus.ready) mode_ff <= csr_bus.silhouette_mode;
      end
   end

   // payload: load on transfer into each stage, hold otherwise
   always_ff @(posedge clock) begin
      if (rdy1 && req_bus.valid) begin
         x1_ff <= x1_in;
         c1_ff <= c1_in;
      end
      if (rdy2 && v1_ff) begin
         x2_ff <= x1_ff;
         q2_ff <= q2_in;
         c2_ff <= c1_ff;
      end
      if (rdy3 && v2_ff) begin
         q3_ff <= q3_in;
         c3_ff <= c2_ff;
      end
      if (rdy4 && v3_ff) begin
         p4_ff <= p4_in;
         c4_ff <= c3_ff;
      end
      if (rdy5 && v4_ff) begin
         gray5_ff <= gray5_in;
         pix5_ff  <= {gray5_in[7:3], gray5_in[7:2], gray5_in[7:3]};
         last5_ff <= c4_ff.last;
      end
   end

   assign rsp_bus.valid      = v5_ff;
   assign rsp_bus.pixel_565  = pix5_ff;
   assign rsp_bus.gray_level = gray5_ff;
   assign rsp_bus.last_out   = last5_ff;

   // an accepted pixel always lands in stage one
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> v1_ff)
      else $error("accepted pixel missing from stage one");

   // reciprocal estimate is off by at most one
   a_quot_fix: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> r3_full[CH_RED] < 17'd510 && r3_full[CH_GREEN] < 17'd510
                && r3_full[CH_BLUE] < 17'd510)
      else $error("quotient estimate out of correction range");

   // a stalled stage four keeps its green product and its control
   a_stage4_hold: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !rdy4 |=> v4_ff && $stable(p4_ff[CH_GREEN]) && $stable(c4_ff))
      else $error("stage four changed under stall");

   // silhouette pixels are pure black or pure white
   a_sil_levels: assert property (@(posedge clock) disable iff (reset)
      v4_ff && rdy5 && c4_ff.sil |=> gray5_ff == 8'd0 || gray5_ff == 8'd255)
      else $error("silhouette gray level not black or white");

endmodule

// ===== tb/rg565_gray_checker.sv =====
// ----------------------------------------------------------------------------
// rg565_gray_checker: scoreboard for the RGBA to gray RGB565 converter
// Watches the pixel, result and mode channels. Predicts the gray result of
// every accepted pixel from its own copy of the mode bit. Compares each
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rg565_gray_checker
   import rg565_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rg565_req_if        req_mon,
   rg565_rsp_if        rsp_mon,
   rg565_csr_if        csr_mon,
   output int unsigned fail_count,
   output int unsigned expected_left
);

   typedef struct packed {
      logic [15:0] pixel_565;
      chan_type    gray_level;
      logic        last_out;
   } gray_result_type;

   logic            sil_mode;
   gray_result_type pending_grays[$];

   // blend over white, take luminance or silhouette, then pack as RGB565
   function automatic gray_result_type predict_gray(input logic sil, input chan_type r,
                                                    input chan_type g, input chan_type b,
                                                    input chan_type a, input logic last);
      int unsigned     cr;
      int unsigned     cg;
      int unsigned     cb;
      int unsigned     av;
      int unsigned     lum;
      chan_type        gray;
      gray_result_type res;
      cr = r;
      cg = g;
      cb = b;
      av = a;
      if (sil) begin
         gray = (av > 128) ? 8'd0 : 8'd255;
      end else begin
         if (av != 255) begin
            cr = (cr * av + 255 * (255 - av)) / 255;
            cg = (cg * av + 255 * (255 - av)) / 255;
            cb = (cb * av + 255 * (255 - av)) / 255;
         end
         lum  = (cr * 77 + cg * 150 + cb * 29) >> 8;
         gray = lum[7:0];
      end
      res.pixel_565  = {gray[7:3], gray[7:2], gray[7:3]};
      res.gray_level = gray;
      res.last_out   = last;
      return res;
   endfunction

   initial begin
      fail_count    = 0;
      expected_left = 0;
      sil_mode      = 1'b0;
   end

   // sample all channels at the rising edge
   always @(posedge clock) begin
      gray_result_type want;
      if (reset) begin
         sil_mode = 1'b0;
         pending_grays.delete();
      end else begin
         // track the mode bit
         if (csr_mon.valid && csr_mon.ready) begin
            sil_mode = csr_mon.silhouette_mode;
         end

         // compare a result transfer with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_grays.size() == 0) begin
               $error("result transfer with no pixel pending: pixel_565=%h", rsp_mon.pixel_565);
               fail_count++;
            end else begin
               want = pending_grays.pop_front();
               if (rsp_mon.pixel_565 !== want.pixel_565) begin
                  $error("pixel_565 expected %h actual %h", want.pixel_565, rsp_mon.pixel_565);
                  fail_count++;
               end
               if (rsp_mon.gray_level !== want.gray_level) begin
                  $error("gray_level expected %0d actual %0d",
                         want.gray_level, rsp_mon.gray_level);
                  fail_count++;
               end
               if (rsp_mon.last_out !== want.last_out) begin
                  $error("last_out expected %b actual %b", want.last_out, rsp_mon.last_out);
                  fail_count++;
               end
            end
         end

         // predict every accepted pixel
         if (req_mon.valid && req_mon.ready) begin
            pending_grays.push_back(predict_gray(sil_mode, req_mon.red, req_mon.green,
                                                 req_mon.blue, req_mon.alpha,
                                                 req_mon.last_pixel));
         end
      end
      expected_left = pending_grays.size();
   end

endmodule

// ===== tb/tb_rgba_to_gray_rgb565.sv =====
// ----------------------------------------------------------------------------
// tb_rgba_to_gray_rgb565: testbench top for the RGBA to gray converter
// Drives directed edge pixels in both modes, then blocks of random pixels
// under changing mode and back-pressure, including one long result stall.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_rgba_to_gray_rgb565;
   import rg565_pkg::*;

   localparam logic        MODE_BLEND      = 1'b0;
   localparam logic        MODE_SILHOUETTE = 1'b1;
   localparam int unsigned PIPE_LATENCY    = 5;
   localparam int unsigned SETTLE_CYCLES   = PIPE_LATENCY + 5;
   localparam int unsigned HOLD_CYCLES     = 300;
   localparam int unsigned WATCHDOG_LIMIT  = 5000;
   localparam int unsigned NUM_BLOCKS      = 6;
   localparam int unsigned BLOCK_PIXELS    = 175;
   // mode per random block, bit n for block n
   localparam logic [5:0]  BLOCK_MODES     = 6'b010010;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned expected_left;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned stall_count;
   logic        hold_armed;

   rg565_req_if req_bus ();
   rg565_rsp_if rsp_bus ();
   rg565_csr_if csr_bus ();

   rgba_to_gray_rgb565 DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   rg565_gray_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_mon       (csr_bus),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   // clock, period 12
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // result side: random stalls, or one long hold when armed
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed) begin
            hold_armed = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stall_count <= 0;
      end else if (stall_count >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // offer one pixel, optionally after a gap; returns at the falling edge after transfer
   task automatic send_pixel(input chan_type r, input chan_type g, input chan_type b,
                             input chan_type a, input logic last);
      int unsigned gap;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 3);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.red        <= r;
      req_bus.green      <= g;
      req_bus.blue       <= b;
      req_bus.alpha      <= a;
      req_bus.last_pixel <= last;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // random pixel with alpha weighted toward opaque, clear and threshold values
   task automatic send_random_pixel();
      chan_type    a;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: begin
            a = 8'd255;
         end
         3: begin
            a = 8'd0;
         end
         4: begin
            a = chan_type'($urandom_range(127, 129));
         end
         default: begin
            a = chan_type'($urandom_range(0, 255));
         end
      endcase
      send_pixel(chan_type'($urandom_range(0, 255)), chan_type'($urandom_range(0, 255)),
                 chan_type'($urandom_range(0, 255)), a, ($urandom_range(0, 15) == 0));
   endtask

   // stop offering and wait until every result is back and the pipe is quiet
   task automatic drain_pipe();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (expected_left != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input logic mode);
      csr_bus.valid           <= 1'b1;
      csr_bus.silhouette_mode <= mode;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      req_bus.valid           = 1'b0;
      req_bus.red             = '0;
      req_bus.green           = '0;
      req_bus.blue            = '0;
      req_bus.alpha           = '0;
      req_bus.last_pixel      = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.silhouette_mode = MODE_BLEND;
      send_idle_pct           = 19;
      recv_idle_pct           = 51;
      stall_count             = 0;
      hold_armed              = 1'b0;
      reset                   = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // blend mode after reset: opaque pass-through, primaries, alpha edges
      send_pixel(8'd0,   8'd0,   8'd0,   8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd0,   8'd0,   8'd255, 1'b0);
      send_pixel(8'd0,   8'd255, 8'd0,   8'd255, 1'b0);
      send_pixel(8'd0,   8'd0,   8'd255, 8'd255, 1'b0);
      send_pixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd0,   1'b0);
      send_pixel(8'd0,   8'd0,   8'd0,   8'd254, 1'b0);
      send_pixel(8'd0,   8'd0,   8'd0,   8'd1,   1'b0);
      send_pixel(8'd0,   8'd0,   8'd0,   8'd128, 1'b0);
      send_pixel(8'd170, 8'd85,  8'd51,  8'd200, 1'b0);
      send_pixel(8'd85,  8'd170, 8'd204, 8'd37,  1'b1);
      drain_pipe();

      // silhouette mode: threshold around 128 and both alpha extremes
      write_mode(MODE_SILHOUETTE);
      send_pixel(8'd0,   8'd0,   8'd0,   8'd128, 1'b0);
      send_pixel(8'd0,   8'd0,   8'd0,   8'd129, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd127, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd0,   1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
      drain_pipe();
      write_mode(MODE_BLEND);

      // random blocks: receiver-heavy idle, sender-heavy idle, then no idle
      for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
         send_idle_pct = (blk < 2) ? 19 : (blk < 4) ? 51 : 0;
         recv_idle_pct = (blk < 2) ? 51 : (blk < 4) ? 19 : 0;
         drain_pipe();
         write_mode(BLOCK_MODES[blk]);
         for (int i = 0; i < BLOCK_PIXELS; i++) begin
            // hold the result side long enough to fill the pipe and stall input
            if (blk == 4 && i == 20) begin
               hold_armed = 1'b1;
            end
            send_random_pixel();
         end
      end
      drain_pipe();

      if (fail_count == 0 && expected_left == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
